@@ src/ecop_pkg.sv @@
// ----------------------------------------------------------------------------
// ecop_pkg: shared types and microprogram for the coprimality tester
// Field widths, transaction payload structs, datapath ops, branch conditions
// and the control store contents.
// ----------------------------------------------------------------------------
package ecop_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned WIDTH_DEFAULT = 32;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t operand_a;
    field_t operand_b;
  } in_data_t;

  typedef struct packed {
    field_t gcd_value;
    logic   coprime;
  } out_data_t;

  // Datapath operations, one per control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_ALIGN,
    OP_REDUCE,
    OP_SWAP,
    OP_EMIT
  } dp_op_e;

  // Branch conditions tested by the sequencer.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_CUR_ZERO,
    C_ALIGNED,
    C_CNT_ZERO,
    C_OUT_FREE
  } cond_e;

  localparam int unsigned UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE   = 3'd0;
  localparam upc_t UPC_TEST   = 3'd1;
  localparam upc_t UPC_INIT   = 3'd2;
  localparam upc_t UPC_ALIGN  = 3'd3;
  localparam upc_t UPC_REDUCE = 3'd4;
  localparam upc_t UPC_SWAP   = 3'd5;
  localparam upc_t UPC_DONE   = 3'd6;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    upc_t   jmp_t;  // taken when cond holds
    upc_t   jmp_f;  // taken otherwise
  } uword_t;

  // Status from datapath to sequencer.
  typedef struct packed {
    logic cur_zero;
    logic aligned;
    logic cnt_zero;
  } dp_flags_t;

  // Control store: Euclid with shift-and-subtract remainder.
  function automatic uword_t ucode(upc_t upc);
    uword_t w;
    case (upc)
      UPC_IDLE:   w = '{op: OP_LOAD,   cond: C_IN_VALID, jmp_t: UPC_TEST,   jmp_f: UPC_IDLE};
      UPC_TEST:   w = '{op: OP_NOP,    cond: C_CUR_ZERO, jmp_t: UPC_DONE,   jmp_f: UPC_INIT};
      UPC_INIT:   w = '{op: OP_INIT,   cond: C_ALWAYS,   jmp_t: UPC_ALIGN,  jmp_f: UPC_ALIGN};
      UPC_ALIGN:  w = '{op: OP_ALIGN,  cond: C_ALIGNED,  jmp_t: UPC_REDUCE, jmp_f: UPC_ALIGN};
      UPC_REDUCE: w = '{op: OP_REDUCE, cond: C_CNT_ZERO, jmp_t: UPC_SWAP,   jmp_f: UPC_REDUCE};
      UPC_SWAP:   w = '{op: OP_SWAP,   cond: C_ALWAYS,   jmp_t: UPC_TEST,   jmp_f: UPC_TEST};
      UPC_DONE:   w = '{op: OP_EMIT,   cond: C_OUT_FREE, jmp_t: UPC_IDLE,   jmp_f: UPC_DONE};
      default:    w = '{op: OP_NOP,    cond: C_ALWAYS,   jmp_t: UPC_IDLE,   jmp_f: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ src/ecop_sequencer.sv @@
// ----------------------------------------------------------------------------
// ecop_sequencer: microprogram counter and branch unit
// Fetches the control word for the current step and picks the next step
// from the word's condition and the datapath flags.
// ----------------------------------------------------------------------------
module ecop_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  input  ecop_pkg::dp_flags_t flags_i,
  output ecop_pkg::dp_op_e   op_o,
  output logic               idle_o
);

  ecop_pkg::upc_t   upc_d, upc_q;
  ecop_pkg::uword_t uword;
  logic             cond_ok;

  assign uword = ecop_pkg::ucode(upc_q);

  always_comb begin
    case (uword.cond)
      ecop_pkg::C_ALWAYS:   cond_ok = 1'b1;
      ecop_pkg::C_IN_VALID: cond_ok = in_valid_i;
      ecop_pkg::C_CUR_ZERO: cond_ok = flags_i.cur_zero;
      ecop_pkg::C_ALIGNED:  cond_ok = flags_i.aligned;
      ecop_pkg::C_CNT_ZERO: cond_ok = flags_i.cnt_zero;
      ecop_pkg::C_OUT_FREE: cond_ok = out_free_i;
      default:              cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    upc_d = cond_ok ? uword.jmp_t : uword.jmp_f;
  end

  always_comb begin
    op_o   = uword.op;
    idle_o = (upc_q == ecop_pkg::UPC_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ecop_pkg::UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ src/ecop_datapath.sv @@
// ----------------------------------------------------------------------------
// ecop_datapath: remainder registers and shift-subtract unit
// Holds the previous and current remainders, the aligned divisor and its
// shift count; one op per cycle as the sequencer commands.
// ----------------------------------------------------------------------------
module ecop_datapath #(
  parameter int unsigned WIDTH = ecop_pkg::WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  ecop_pkg::dp_op_e    op_i,
  input  ecop_pkg::in_data_t  in_data_i,
  output ecop_pkg::dp_flags_t flags_o,
  output ecop_pkg::out_data_t result_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;

  word_t            r0_d, r0_q;  // previous remainder, becomes gcd
  word_t            r1_d, r1_q;  // current remainder
  word_t            d_d, d_q;    // divisor shifted into alignment
  logic [CNT_W-1:0] k_d, k_q;
  logic [WIDTH:0]   d_dbl;
  logic             aligned;

  assign d_dbl   = {d_q, 1'b0};
  // stop shifting when the next doubling would pass r0 or overflow
  assign aligned = d_q[WIDTH-1] || (d_dbl > {1'b0, r0_q});

  always_comb begin
    r0_d = r0_q;
    r1_d = r1_q;
    d_d  = d_q;
    k_d  = k_q;
    case (op_i)
      ecop_pkg::OP_LOAD: begin
        r0_d = word_t'(in_data_i.operand_a);
        r1_d = word_t'(in_data_i.operand_b);
      end
      ecop_pkg::OP_INIT: begin
        d_d = r1_q;
        k_d = '0;
      end
      ecop_pkg::OP_ALIGN: begin
        if (!aligned) begin
          d_d = d_q << 1;
          k_d = k_q + 1'b1;
        end
      end
      ecop_pkg::OP_REDUCE: begin
        if (r0_q >= d_q) begin
          r0_d = r0_q - d_q;
        end
        if (k_q != '0) begin
          d_d = d_q >> 1;
          k_d = k_q - 1'b1;
        end
      end
      ecop_pkg::OP_SWAP: begin
        r0_d = r1_q;
        r1_d = r0_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
    d_q  <= d_d;
    k_q  <= k_d;
  end

  always_comb begin
    flags_o.cur_zero   = (r1_q == '0);
    flags_o.aligned    = aligned;
    flags_o.cnt_zero   = (k_q == '0);
    result_o.gcd_value = ecop_pkg::field_t'(r0_q);
    result_o.coprime   = (r0_q == word_t'(1));
  end

endmodule

@@ src/euclid_coprimality_test.sv @@
// Each remainder step shifts the divisor up into alignment, then subtracts
//   and shifts it back down, so the time from accept to out_valid_o depends
//   on the operands. A stalled output register holds the sequence at its last step.
// One transaction in flight; the next is accepted only once the result has
//   been emitted and the sequencer is back at idle. Reset clears the step
//   counter and out_valid_o.
// ----------------------------------------------------------------------------
// euclid_coprimality_test: gcd and coprimality flag of two operands
// Microcoded Euclid sequence with a registered result.
// ----------------------------------------------------------------------------
module euclid_coprimality_test #(
  parameter int unsigned WIDTH = ecop_pkg::WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ecop_pkg::in_data_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecop_pkg::out_data_t out_data_o
);

  ecop_pkg::dp_op_e    op;
  ecop_pkg::dp_flags_t flags;
  ecop_pkg::out_data_t result;
  ecop_pkg::out_data_t out_data_q;
  logic                idle;
  logic                out_free;
  logic                emit;
  logic                out_valid_d, out_valid_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (op == ecop_pkg::OP_EMIT) && out_free;

  ecop_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .flags_i    (flags),
    .op_o       (op),
    .idle_o     (idle)
  );

  ecop_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .op_i      (op),
    .in_data_i (in_data_i),
    .flags_o   (flags),
    .result_o  (result)
  );

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
    end
  end

  assign in_ready_o  = idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/ecop_checker.sv @@
// ----------------------------------------------------------------------------
// ecop_checker: port-level checks for the coprimality tester
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module ecop_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ecop_pkg::in_data_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ecop_pkg::out_data_t out_data_o
);

  // a waiting result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.coprime == (out_data_o.gcd_value == 1)))
    else $error("coprime flag disagrees with gcd");

  // one transaction at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready high right after accept");

  // the flop is cleared by the first edge seen in reset
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // a new result is only written while the block is busy
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

endmodule

bind euclid_coprimality_test ecop_checker u_ecop_checker (.*);

@@ dv/euclid_coprimality_test_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euclid_coprimality_test_checker: scoreboard for the gcd/coprimality block
// Watches both channels, computes the gcd and flag of every accepted operand
// pair and compares each result transaction, in order, field by field.
// ----------------------------------------------------------------------------
module euclid_coprimality_test_checker #(
  parameter int unsigned WIDTH = ecop_pkg::WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ecop_pkg::in_data_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ecop_pkg::out_data_t out_data_i,
  output int                  fail_count_o,
  output int                  results_checked_o,
  output int                  coprime_seen_o,
  output int                  expected_left_o
);

  typedef struct {
    ecop_pkg::in_data_t  pair;
    ecop_pkg::out_data_t result;
  } gcd_case_t;

  gcd_case_t pending_gcd_q[$];

  initial begin
    fail_count_o      = 0;
    results_checked_o = 0;
    coprime_seen_o    = 0;
    expected_left_o   = 0;
  end

  // Plain remainder sequence; operands cut to the datapath width first.
  function automatic ecop_pkg::out_data_t predict_gcd(ecop_pkg::in_data_t pair);
    logic [63:0]         mask, prev, cur, rem;
    ecop_pkg::out_data_t res;
    mask = {64{1'b1}} >> (64 - WIDTH);
    prev = 64'(pair.operand_a) & mask;
    cur  = 64'(pair.operand_b) & mask;
    while (cur != 64'd0) begin
      rem  = prev % cur;
      prev = cur;
      cur  = rem;
    end
    res.gcd_value = prev[ecop_pkg::FIELD_W-1:0];
    res.coprime   = (prev == 64'd1);
    return res;
  endfunction

  always @(posedge clk_i) begin
    gcd_case_t oldest;
    if (rst_ni) begin
      // results first: the one in flight always belongs to an older pair
      if (out_valid_i && out_ready_i) begin
        if (pending_gcd_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result gcd=%0d coprime=%0b", $time,
                   out_data_i.gcd_value, out_data_i.coprime);
        end else begin
          oldest = pending_gcd_q.pop_front();
          results_checked_o++;
          if (out_data_i.coprime === 1'b1) coprime_seen_o++;
          if (out_data_i.gcd_value !== oldest.result.gcd_value) begin
            fail_count_o++;
            $display("%0t: gcd(%0d, %0d) expected gcd_value=%0d actual=%0d", $time,
                     oldest.pair.operand_a, oldest.pair.operand_b,
                     oldest.result.gcd_value, out_data_i.gcd_value);
          end
          if (out_data_i.coprime !== oldest.result.coprime) begin
            fail_count_o++;
            $display("%0t: gcd(%0d, %0d) expected coprime=%0b actual=%0b", $time,
                     oldest.pair.operand_a, oldest.pair.operand_b,
                     oldest.result.coprime, out_data_i.coprime);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_gcd_q.push_back('{pair: in_data_i, result: predict_gcd(in_data_i)});
      end
      expected_left_o = pending_gcd_q.size();
    end
  end

endmodule

@@ dv/euclid_coprimality_test_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euclid_coprimality_test_test: testbench top for the gcd/coprimality block
// Drives corner operand pairs, then random pairs (shared factors, Fibonacci
// worst cases, small and zero operands) under four idle/stall mixes.
// ----------------------------------------------------------------------------
module euclid_coprimality_test_test;

  localparam int unsigned      RANDOM_PER_PHASE = 483;
  localparam int unsigned      STALL_LIMIT      = 5000;
  localparam int unsigned      DRAIN_CYCLES     = 300;
  localparam ecop_pkg::field_t ALL_ONES         = '1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  ecop_pkg::in_data_t  in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  ecop_pkg::out_data_t out_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pairs_sent     = 0;
  int unsigned quiet_cycles   = 0;
  int          fail_count;
  int          results_checked;
  int          coprime_seen;
  int          expected_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  euclid_coprimality_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  euclid_coprimality_test_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_data_i         (in_data_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_i        (out_data_o),
    .fail_count_o      (fail_count),
    .results_checked_o (results_checked),
    .coprime_seen_o    (coprime_seen),
    .expected_left_o   (expected_left)
  );

  always @(negedge clk_i) begin
    out_ready_i = rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("euclid_coprimality_test_test NOT OK");
        $finish;
      end
    end
  end

  function automatic ecop_pkg::in_data_t pair_of(ecop_pkg::field_t a, ecop_pkg::field_t b);
    ecop_pkg::in_data_t p;
    p.operand_a = a;
    p.operand_b = b;
    return p;
  endfunction

  function automatic ecop_pkg::field_t fib(int unsigned n);
    ecop_pkg::field_t f0, f1, t;
    f0 = 0;
    f1 = 1;
    repeat (n) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  function automatic ecop_pkg::in_data_t random_pair();
    ecop_pkg::field_t a, b, f, t;
    int unsigned      n;
    case ($urandom_range(9))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3: begin  // shared factor
        f = $urandom_range(65536, 2);
        a = f * $urandom_range(32'hFFFF_FFFF / f);
        b = f * $urandom_range(32'hFFFF_FFFF / f);
      end
      4: begin
        a = $urandom_range(15);
        b = $urandom_range(15);
      end
      5: begin
        a = $urandom >> $urandom_range(31);
        b = $urandom >> $urandom_range(31);
      end
      6: begin  // one divides the other, equal included
        f = $urandom_range(65535, 1);
        a = f;
        b = f * $urandom_range(32'hFFFF_FFFF / f, 1);
      end
      7: begin  // consecutive Fibonacci: longest remainder chains
        n = $urandom_range(47, 2);
        a = fib(n);
        b = fib(n - 1);
      end
      8: begin
        a = $urandom;
        b = $urandom_range(2);
      end
      default: begin
        a = $urandom_range(65535);
        b = $urandom;
      end
    endcase
    if ($urandom_range(1)) begin
      t = a;
      a = b;
      b = t;
    end
    return pair_of(a, b);
  endfunction

  // Leaves the caller at a falling edge with valid still high.
  task automatic send_pair(input ecop_pkg::in_data_t pair);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = pair;
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    int unsigned directed_cnt;
    idle_by_phase  = '{0, 76, 0, 15};
    stall_by_phase = '{0, 0, 76, 15};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corner pairs, no idling
    send_pair(pair_of(0, 0));
    send_pair(pair_of(0, 1));
    send_pair(pair_of(1, 0));
    send_pair(pair_of(0, ALL_ONES));
    send_pair(pair_of(ALL_ONES, 0));
    send_pair(pair_of(7, 0));
    send_pair(pair_of(0, 12));
    send_pair(pair_of(1, 1));
    send_pair(pair_of(2, 2));
    send_pair(pair_of(ALL_ONES, ALL_ONES));
    send_pair(pair_of(ALL_ONES, 1));
    send_pair(pair_of(1, ALL_ONES));
    send_pair(pair_of(ALL_ONES, ALL_ONES - 1));
    send_pair(pair_of(12, 18));
    send_pair(pair_of(18, 12));
    send_pair(pair_of(6, 35));
    send_pair(pair_of(fib(47), fib(46)));
    send_pair(pair_of(fib(46), fib(47)));
    send_pair(pair_of(32'h8000_0000, 32'h4000_0000));
    send_pair(pair_of(32'h8000_0000, 3));
    send_pair(pair_of(32'd4294967291, 32'd4294967279));
    send_pair(pair_of(32'd65536 * 21, 32'd65536 * 35));
    directed_cnt = pairs_sent;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      repeat (RANDOM_PER_PHASE) send_pair(random_pair());
    end
    in_valid_i = 1'b0;

    while (expected_left != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d operand pairs (%0d directed) over four idle/stall mixes;",
             pairs_sent, directed_cnt);
    $display("%0d results checked, %0d of them coprime.", results_checked, coprime_seen);
    if (fail_count == 0) begin
      $display("euclid_coprimality_test_test OK");
    end else begin
      $display("euclid_coprimality_test_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ecop_pkg.sv
src/ecop_sequencer.sv
src/ecop_datapath.sv
src/euclid_coprimality_test.sv
src/ecop_checker.sv
dv/euclid_coprimality_test_checker.sv
dv/euclid_coprimality_test_test.sv
